>>> rtl/e3x_pkg.sv
// ----------------------------------------------------------------------------
// e3x_pkg
// Shared constants, request codes and the exponential factor table of the
// Exp3-IX bandit selector.
// ----------------------------------------------------------------------------
package e3x_pkg;

    localparam int MAX_ARMS = 16;
    localparam int ARM_W    = 4;
    localparam int CFG_W    = 5;
    localparam int WGT_W    = 32;
    localparam int TOT_W    = 36;
    localparam int PROB_W   = 17;
    localparam int SCORE_W  = 17;
    localparam int X_W      = 18;

    localparam logic [WGT_W-1:0]   ONE_Q31   = 32'h8000_0000;
    localparam logic [31:0]        LN2_Q32   = 32'hB172_17F8;
    localparam logic [X_W-1:0]     X_MAX     = 18'h3FFFF;
    localparam logic [SCORE_W-1:0] SCORE_ONE = 17'h10000;

    typedef enum logic [1:0] {
        REQ_RESET  = 2'd0,
        REQ_SELECT = 2'd1,
        REQ_UPDATE = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    // exp(-2^(k-16)) in Q0.32.
    function automatic logic [31:0] exp_neg_factor(input logic [4:0] k);
        logic [31:0] f;
        case (k)
            5'd0:    f = 32'hFFFF0000;
            5'd1:    f = 32'hFFFE0002;
            5'd2:    f = 32'hFFFC0008;
            5'd3:    f = 32'hFFF80020;
            5'd4:    f = 32'hFFF00080;
            5'd5:    f = 32'hFFE00200;
            5'd6:    f = 32'hFFC007FF;
            5'd7:    f = 32'hFF801FFB;
            5'd8:    f = 32'hFF007FD5;
            5'd9:    f = 32'hFE01FEAB;
            5'd10:   f = 32'hFC07F560;
            5'd11:   f = 32'hF81FAB54;
            5'd12:   f = 32'hF07D5FDE;
            5'd13:   f = 32'hE1EB5127;
            5'd14:   f = 32'hC75F7CF5;
            5'd15:   f = 32'h9B4597E3;
            5'd16:   f = 32'h5E2D58D9;
            5'd17:   f = 32'h22A55547;
            default: f = 32'h0000_0000;
        endcase
        return f;
    endfunction

endpackage

>>> rtl/exp3ix_bandit_selector.sv
// ----------------------------------------------------------------------------
// exp3ix_bandit_selector
// Exp3-IX multi-armed bandit: weight reset, arm selection and score update.
// ----------------------------------------------------------------------------
// The block takes one request beat at a time and holds s_tready low until the
// result beat has been loaded into the output register. A weight reset and a
// selection (one arm per cycle in the walk) each end in one probability
// division; an update takes longest. The shared restoring divider retires one
// quotient bit per cycle and runs once per result plus up to three more times
// in an update; an update also runs the 32-step square root, 24 squaring
// rounds for ln n and 18 exponential factor steps, the last two on the single
// shared 32x32 multiplier.
module exp3ix_bandit_selector
    import e3x_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,   // arm_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,    // random_draw[31:0], arm[35:32], score[52:36]
    input  logic [1:0]  s_tuser,    // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata     // selected_arm[3:0], arm_probability[20:4]
);

    typedef enum logic [18:0] {
        ST_IDLE       = 19'h00001,
        ST_RESET_W    = 19'h00002,
        ST_SEL_LO     = 19'h00004,
        ST_SEL_HI     = 19'h00008,
        ST_WALK       = 19'h00010,
        ST_TN_MUL     = 19'h00020,
        ST_LN_SQ      = 19'h00040,
        ST_LN_MUL     = 19'h00080,
        ST_DIV        = 19'h00100,
        ST_SQRT       = 19'h00200,
        ST_P_START    = 19'h00400,
        ST_P_DONE     = 19'h00800,
        ST_X_MUL      = 19'h01000,
        ST_X_DONE     = 19'h02000,
        ST_EXP        = 19'h04000,
        ST_WRITE      = 19'h08000,
        ST_PROB_START = 19'h10000,
        ST_PROB_DONE  = 19'h20000,
        ST_DONE       = 19'h40000
    } state_t;

    state_t             state_reg, state_next;
    state_t             ret_reg, ret_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [CFG_W-1:0]   arm_count_reg, arm_count_next;
    logic [WGT_W-1:0]   weight_reg [MAX_ARMS];
    logic [WGT_W-1:0]   weight_next [MAX_ARMS];
    logic [TOT_W-1:0]   total_reg, total_next;
    logic [31:0]        iter_reg, iter_next;
    logic [31:0]        draw_reg, draw_next;
    logic [SCORE_W-1:0] score_reg, score_next;
    logic [ARM_W-1:0]   sel_reg, sel_next;
    logic [63:0]        a_reg, a_next;
    logic [39:0]        r_reg, r_next;
    logic [39:0]        dsr_reg, dsr_next;
    logic [63:0]        s_reg, s_next;
    logic [63:0]        b_reg, b_next;
    logic [38:0]        g2den_reg, g2den_next;
    logic [2:0]         e_reg, e_next;
    logic [23:0]        frac_reg, frac_next;
    logic [31:0]        m_reg, m_next;
    logic [30:0]        gamma_reg, gamma_next;
    logic [30:0]        p_reg, p_next;
    logic [X_W-1:0]     x_reg, x_next;
    logic [WGT_W-1:0]   oldw_reg, oldw_next;
    logic [WGT_W-1:0]   acc_reg, acc_next;
    logic [36:0]        target_reg, target_next;
    logic [36:0]        cum_reg, cum_next;
    logic [PROB_W-1:0]  prob_reg, prob_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [23:0]        m_tdata_reg, m_tdata_next;

    logic [CFG_W-1:0]   n_eff;
    logic [2:0]         n_log;
    logic [WGT_W-1:0]   w_rd;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_p;
    logic [40:0]        div_rs;
    logic               div_ge;
    logic [63:0]        sq_sum;
    logic [36:0]        walk_sum;
    logic [31:0]        x_den;
    logic [WGT_W-1:0]   new_w;
    logic [WGT_W-1:0]   w_dec;
    logic [SCORE_W-1:0] score_in;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb
    begin
        if (arm_count_reg == '0)
            n_eff = CFG_W'(1);
        else if (arm_count_reg > CFG_W'(MAX_ARMS))
            n_eff = CFG_W'(MAX_ARMS);
        else
            n_eff = arm_count_reg;
    end

    always_comb
    begin
        if (n_eff[4])
            n_log = 3'd4;
        else if (n_eff[3])
            n_log = 3'd3;
        else if (n_eff[2])
            n_log = 3'd2;
        else if (n_eff[1])
            n_log = 3'd1;
        else
            n_log = 3'd0;
    end

    assign w_rd = weight_reg[sel_reg];

    // The one multiplier, shared by every step that needs a product.
    always_comb
    begin
        case (state_reg)
            ST_SEL_LO:
            begin
                mul_a = draw_reg;
                mul_b = total_reg[31:0];
            end
            ST_SEL_HI:
            begin
                mul_a = draw_reg;
                mul_b = {28'd0, total_reg[35:32]};
            end
            ST_TN_MUL:
            begin
                mul_a = iter_reg;
                mul_b = 32'(n_eff);
            end
            ST_LN_SQ:
            begin
                mul_a = m_reg;
                mul_b = m_reg;
            end
            ST_LN_MUL:
            begin
                mul_a = {5'd0, e_reg, frac_reg};
                mul_b = LN2_Q32;
            end
            ST_X_MUL:
            begin
                mul_a = {1'b0, gamma_reg};
                mul_b = {15'd0, SCORE_ONE - score_reg};
            end
            ST_EXP:
            begin
                mul_a = acc_reg;
                mul_b = exp_neg_factor(cnt_reg[4:0]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = 64'(mul_a) * 64'(mul_b);
    assign div_rs   = {r_reg, a_reg[63]};
    assign div_ge   = (div_rs >= {1'b0, dsr_reg});
    assign sq_sum   = s_reg + b_reg;
    assign walk_sum = cum_reg + 37'(w_rd);
    assign x_den    = 32'(p_reg) + 32'(gamma_reg);
    assign new_w    = (acc_reg == '0) ? WGT_W'(1) : acc_reg;
    assign w_dec    = oldw_reg - new_w;
    assign score_in = (s_tdata[52:36] > SCORE_ONE) ? SCORE_ONE : s_tdata[52:36];

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        cnt_next       = cnt_reg;
        arm_count_next = arm_count_reg;
        weight_next    = weight_reg;
        total_next     = total_reg;
        iter_next      = iter_reg;
        draw_next      = draw_reg;
        score_next     = score_reg;
        sel_next       = sel_reg;
        a_next         = a_reg;
        r_next         = r_reg;
        dsr_next       = dsr_reg;
        s_next         = s_reg;
        b_next         = b_reg;
        g2den_next     = g2den_reg;
        e_next         = e_reg;
        frac_next      = frac_reg;
        m_next         = m_reg;
        gamma_next     = gamma_reg;
        p_next         = p_reg;
        x_next         = x_reg;
        oldw_next      = oldw_reg;
        acc_next       = acc_reg;
        target_next    = target_reg;
        cum_next       = cum_reg;
        prob_next      = prob_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;

        if (cfg_valid && cfg_ready)
            arm_count_next = cfg_data;

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    draw_next  = s_tdata[31:0];
                    score_next = score_in;
                    case (req_t'(s_tuser))
                        REQ_RESET:
                            state_next = ST_RESET_W;
                        REQ_SELECT:
                            state_next = ST_SEL_LO;
                        REQ_UPDATE:
                        begin
                            sel_next = s_tdata[35:32];
                            if ({1'b0, s_tdata[35:32]} < n_eff)
                                state_next = ST_TN_MUL;
                            else
                            begin
                                prob_next  = '0;
                                state_next = ST_DONE;
                            end
                        end
                        default:
                        begin
                            sel_next   = '0;
                            prob_next  = '0;
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_RESET_W:
            begin
                for (int i = 0; i < MAX_ARMS; i++)
                    weight_next[i] = ONE_Q31;
                total_next = TOT_W'(n_eff) << 31;
                iter_next  = 32'd1;
                sel_next   = '0;
                state_next = ST_PROB_START;
            end
            ST_SEL_LO:
            begin
                a_next     = mul_p;
                state_next = ST_SEL_HI;
            end
            ST_SEL_HI:
            begin
                // Target is the draw times the total, rounded up.
                target_next = 37'(mul_p[35:0]) + 37'(a_reg[63:32])
                            + 37'(a_reg[31:0] != '0);
                cum_next    = '0;
                sel_next    = '0;
                state_next  = ST_WALK;
            end
            ST_WALK:
            begin
                if ({1'b0, sel_reg} == n_eff - CFG_W'(1))
                    state_next = ST_PROB_START;
                else if (walk_sum >= target_reg)
                    state_next = ST_PROB_START;
                else
                begin
                    cum_next = walk_sum;
                    sel_next = sel_reg + ARM_W'(1);
                end
            end
            ST_TN_MUL:
            begin
                oldw_next  = w_rd;
                g2den_next = {mul_p[36:0], 2'b00};
                e_next     = n_log;
                m_next     = 32'(n_eff) << (5'd30 - {2'b00, n_log});
                frac_next  = '0;
                cnt_next   = '0;
                state_next = ST_LN_SQ;
            end
            ST_LN_SQ:
            begin
                // One fraction bit of log2 n per squaring round.
                frac_next = {frac_reg[22:0], mul_p[61]};
                m_next    = mul_p[61] ? {1'b0, mul_p[61:31]} : mul_p[61:30];
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == 6'd23)
                    state_next = ST_LN_MUL;
            end
            ST_LN_MUL:
            begin
                a_next     = {mul_p[59:32], 36'd0};
                dsr_next   = {1'b0, g2den_reg};
                r_next     = '0;
                cnt_next   = '0;
                s_next     = '0;
                b_next     = 64'h4000_0000_0000_0000;
                ret_next   = ST_SQRT;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                r_next   = div_ge ? 40'(div_rs - {1'b0, dsr_reg}) : div_rs[39:0];
                a_next   = {a_reg[62:0], div_ge};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    cnt_next   = '0;
                    state_next = ret_reg;
                end
            end
            ST_SQRT:
            begin
                if (a_reg >= sq_sum)
                begin
                    a_next = a_reg - sq_sum;
                    s_next = (s_reg >> 1) + b_reg;
                end
                else
                    s_next = s_reg >> 1;
                b_next   = b_reg >> 2;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                    state_next = ST_P_START;
            end
            ST_P_START:
            begin
                gamma_next = s_reg[30:0];
                if (total_reg == '0)
                begin
                    p_next     = '0;
                    state_next = ST_X_MUL;
                end
                else
                begin
                    a_next     = {2'b00, oldw_reg, 30'd0};
                    dsr_next   = {4'd0, total_reg};
                    r_next     = '0;
                    cnt_next   = '0;
                    ret_next   = ST_P_DONE;
                    state_next = ST_DIV;
                end
            end
            ST_P_DONE:
            begin
                p_next     = (a_reg > 64'h4000_0000) ? 31'h4000_0000 : a_reg[30:0];
                state_next = ST_X_MUL;
            end
            ST_X_MUL:
            begin
                if (x_den == '0)
                begin
                    x_next     = X_MAX;
                    acc_next   = oldw_reg;
                    cnt_next   = '0;
                    state_next = ST_EXP;
                end
                else
                begin
                    a_next     = {15'd0, mul_p[47:0], 1'b0};
                    dsr_next   = 40'(x_den);
                    r_next     = '0;
                    cnt_next   = '0;
                    ret_next   = ST_X_DONE;
                    state_next = ST_DIV;
                end
            end
            ST_X_DONE:
            begin
                x_next     = (a_reg > 64'(X_MAX)) ? X_MAX : a_reg[X_W-1:0];
                acc_next   = oldw_reg;
                cnt_next   = '0;
                state_next = ST_EXP;
            end
            ST_EXP:
            begin
                // The argument is consumed from its low bit up.
                if (x_reg[0])
                    acc_next = mul_p[63:32];
                x_next   = x_reg >> 1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(X_W - 1))
                    state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                weight_next[sel_reg] = new_w;
                if (total_reg < TOT_W'(w_dec))
                    total_next = TOT_W'(new_w);
                else
                    total_next = total_reg - TOT_W'(w_dec);
                if (iter_reg != 32'hFFFF_FFFF)
                    iter_next = iter_reg + 32'd1;
                state_next = ST_PROB_START;
            end
            ST_PROB_START:
            begin
                if (total_reg == '0)
                begin
                    prob_next  = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    a_next     = {16'd0, w_rd, 16'd0};
                    dsr_next   = {4'd0, total_reg};
                    r_next     = '0;
                    cnt_next   = '0;
                    ret_next   = ST_PROB_DONE;
                    state_next = ST_DIV;
                end
            end
            ST_PROB_DONE:
            begin
                prob_next  = (a_reg > 64'(SCORE_ONE)) ? SCORE_ONE : a_reg[PROB_W-1:0];
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tdata_next  = {3'd0, prob_reg, sel_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            cnt_reg       <= '0;
            arm_count_reg <= CFG_W'(MAX_ARMS);
            for (int i = 0; i < MAX_ARMS; i++)
                weight_reg[i] <= ONE_Q31;
            total_reg     <= TOT_W'(MAX_ARMS) << 31;
            iter_reg      <= 32'd1;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            cnt_reg       <= cnt_next;
            arm_count_reg <= arm_count_next;
            weight_reg    <= weight_next;
            total_reg     <= total_next;
            iter_reg      <= iter_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        draw_reg   <= draw_next;
        score_reg  <= score_next;
        sel_reg    <= sel_next;
        a_reg      <= a_next;
        r_reg      <= r_next;
        dsr_reg    <= dsr_next;
        s_reg      <= s_next;
        b_reg      <= b_next;
        g2den_reg  <= g2den_next;
        e_reg      <= e_next;
        frac_reg   <= frac_next;
        m_reg      <= m_next;
        gamma_reg  <= gamma_next;
        p_reg      <= p_next;
        x_reg      <= x_next;
        oldw_reg   <= oldw_next;
        acc_reg    <= acc_next;
        target_reg <= target_next;
        cum_reg    <= cum_next;
        prob_reg   <= prob_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

>>> rtl/e3x_checker.sv
// ----------------------------------------------------------------------------
// e3x_checker
// Port-level checks for the Exp3-IX bandit selector, bound to the top level.
// ----------------------------------------------------------------------------
module e3x_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // A request beat keeps the block busy for at least the next cycle.
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again right after a beat");

    // A probability never exceeds 1.0.
    a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[20:4] <= 17'h10000))
        else $error("probability above one");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat changed under stall");

endmodule

bind exp3ix_bandit_selector e3x_checker u_e3x_checker (.*);
